// File: rtl/biquad_pkg.sv
// Shared types and constants for the Q1.15 biquad filter.
// Holds the sequencer state type, register indexes and the Q15 multiply helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package biquad_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic signed [SAMPLE_W-1:0] Q15_MAX    = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] Q15_MIN    = -16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] GAIN_RESET = 16'sd2949;

  localparam logic [CFG_IDX_W-1:0] REG_B0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A1   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A2   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN = 3'd5;

  // MAC sequence order
  localparam logic [2:0] STEP_B0   = 3'd0;
  localparam logic [2:0] STEP_B1   = 3'd1;
  localparam logic [2:0] STEP_A1   = 3'd2;
  localparam logic [2:0] STEP_B2   = 3'd3;
  localparam logic [2:0] STEP_A2   = 3'd4;
  localparam logic [2:0] STEP_GAIN = 3'd5;

  typedef enum logic {
    ST_IDLE,
    ST_MAC
  } bq_state_t;

  function automatic logic signed [SAMPLE_W-1:0] sat17(input logic signed [SAMPLE_W:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v > 17'sd32767) begin
      r = Q15_MAX;
    end else if (v < -17'sd32768) begin
      r = Q15_MIN;
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  // Q15 product, floor-truncated; only -1 * -1 overflows
  function automatic logic signed [SAMPLE_W-1:0] q15_mul(
    input logic signed [SAMPLE_W-1:0] a,
    input logic signed [SAMPLE_W-1:0] b
  );
    logic signed [2*SAMPLE_W-1:0] p;
    p = a * b;
    return sat17(p[2*SAMPLE_W-1:SAMPLE_W-1]);
  endfunction

endpackage

`default_nettype wire

// File: rtl/biquad_iir_q15.sv
// Second-order IIR filter, direct form I, signed Q1.15 samples.
// Top level; depends on biquad_pkg.
`timescale 1ns / 1ps
`default_nettype none

// One input item yields one output item. A single 16x16 multiplier with a
// saturating accumulator runs the five taps and the output gain in turn (b0,
// b1, a1, b2, a2, gain). After an item is accepted, in_tready stays low while
// those steps run and returns high as the result enters the output register.
// The block takes a new item only from its idle state, so it takes no new
// item before the last result is in the output register. A result still
// waiting on out_tready holds the last step until the output register frees.
// Write coefficients via cfg_* only while idle; the block does not check it.
module biquad_iir_q15 (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire [15:0] in_tdata,    // [15:0] sample_in
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [15:0] out_tdata,  // [15:0] sample_out
  input  wire        cfg_wr_en,
  input  wire [biquad_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [15:0] cfg_wr_data
);
  import biquad_pkg::*;

  bq_state_t state_r, state_nxt;
  logic [2:0] step_r, step_nxt;

  logic signed [SAMPLE_W-1:0] b0_r, b1_r, b2_r, a1_r, a2_r, gain_r;
  logic signed [SAMPLE_W-1:0] x_r, x1_r, x2_r, y1_r, y2_r, acc_r;
  logic signed [SAMPLE_W-1:0] acc_nxt;
  logic               out_tvalid_r;
  logic [SAMPLE_W-1:0] out_tdata_r;

  logic signed [SAMPLE_W-1:0] mul_a, mul_b, prod;
  logic signed [SAMPLE_W:0]   sum;
  logic mac_sub, mac_first, mac_en, upd_delay, load_out, slot_free, in_acc;

  assign in_acc    = in_tvalid && in_tready;
  assign slot_free = !out_tvalid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_MAC;
          step_nxt  = STEP_B0;
        end
      end
      ST_MAC: begin
        if (step_r == STEP_GAIN) begin
          if (slot_free) begin
            state_nxt = ST_IDLE;
          end
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    mul_a     = gain_r;
    mul_b     = acc_r;
    mac_sub   = 1'b0;
    mac_first = 1'b0;
    mac_en    = 1'b0;
    upd_delay = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
      end
      ST_MAC: begin
        case (step_r)
          STEP_B0: begin
            mul_a = b0_r; mul_b = x_r; mac_first = 1'b1; mac_en = 1'b1;
          end
          STEP_B1: begin
            mul_a = b1_r; mul_b = x1_r; mac_en = 1'b1;
          end
          STEP_A1: begin
            mul_a = a1_r; mul_b = y1_r; mac_sub = 1'b1; mac_en = 1'b1;
          end
          STEP_B2: begin
            mul_a = b2_r; mul_b = x2_r; mac_en = 1'b1;
          end
          STEP_A2: begin
            mul_a = a2_r; mul_b = y2_r; mac_sub = 1'b1; mac_en = 1'b1;
            upd_delay = 1'b1;
          end
          default: begin
            load_out = slot_free;
          end
        endcase
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // shared multiplier and saturating accumulator
  assign prod = q15_mul(mul_a, mul_b);
  always_comb begin
    if (mac_sub) begin
      sum = {acc_r[SAMPLE_W-1], acc_r} - {prod[SAMPLE_W-1], prod};
    end else if (mac_first) begin
      sum = {prod[SAMPLE_W-1], prod};
    end else begin
      sum = {acc_r[SAMPLE_W-1], acc_r} + {prod[SAMPLE_W-1], prod};
    end
    acc_nxt = sat17(sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= STEP_B0;
      out_tvalid_r <= 1'b0;
      b0_r         <= '0;
      b1_r         <= '0;
      b2_r         <= '0;
      a1_r         <= '0;
      a2_r         <= '0;
      gain_r       <= GAIN_RESET;
      x1_r         <= '0;
      x2_r         <= '0;
      y1_r         <= '0;
      y2_r         <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (load_out) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_B0:   b0_r   <= cfg_wr_data;
          REG_B1:   b1_r   <= cfg_wr_data;
          REG_B2:   b2_r   <= cfg_wr_data;
          REG_A1:   a1_r   <= cfg_wr_data;
          REG_A2:   a2_r   <= cfg_wr_data;
          REG_GAIN: gain_r <= cfg_wr_data;
          default: begin
          end
        endcase
      end
      if (upd_delay) begin
        x2_r <= x1_r;
        x1_r <= x_r;
        y2_r <= y1_r;
        y1_r <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r <= in_tdata;
    end
    if (mac_en) begin
      acc_r <= acc_nxt;
    end
    if (load_out) begin
      out_tdata_r <= prod;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire

// File: rtl/biquad_chk.sv
// Port-level assertions for biquad_iir_q15, bound to the top level.
// Depends on biquad_iir_q15 (bind target) and biquad_pkg.
`timescale 1ns / 1ps
`default_nettype none

module biquad_chk (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [15:0] out_tdata
);
  import biquad_pkg::*;

  // busy after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("in_tready high right after an accepted item");

  // going idle coincides with a result entering the output register
  a_idle_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_tready) && $past(rst_n) |-> out_tvalid)
    else $error("block went idle without a pending result");

  // no result appears unless an item was in flight
  a_no_spurious_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) && $past(rst_n) |-> $past(!in_tready))
    else $error("result produced with no item in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind biquad_iir_q15 biquad_chk u_biquad_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
